// File: rtl/csd_pkg.sv
// Shared types, constants and the code-to-character map for the letter-case decoder.
// Used by the channel interfaces, the decoder core, the result queue and the top level.
package csd_pkg;

   // Field widths.
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int CODE_W   = 6;
   localparam int BITS_W   = 3;

   // Register reset value: the full count range.
   localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 16'hFFFF;

   // Code ranges of the character map.
   localparam logic [CODE_W-1:0] CODE_LAST_ALPHA = 6'd25;
   localparam logic [CODE_W-1:0] CODE_LAST_PUNCT = 6'd35;
   localparam logic [CODE_W-1:0] CODE_LAST_SIGN  = 6'd39;
   localparam logic [CODE_W-1:0] CODE_LAST_DIGIT = 6'd49;
   localparam logic [CODE_W-1:0] CODE_LAST_COLON = 6'd51;
   localparam logic [CODE_W-1:0] CODE_QUESTION   = 6'd52;
   localparam logic [CODE_W-1:0] CODE_EOM        = 6'd63;

   // Letters already held when the next letter completes one code.
   localparam logic [BITS_W-1:0] BITS_LAST = 3'd5;

   // Result kinds.
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Final status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MARKER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 2'd3;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic                result_kind;
      logic [CHAR_W-1:0]   out_char;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  char_count;
   } result_type;

   // Results produced by one accepted byte; second is only ever the status.
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

   // Maps a six-bit code to {valid, character}.
   function automatic logic [CHAR_W:0] map_code(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] code8;
      logic [CHAR_W-1:0] ch;
      logic              ok;
      code8 = {2'b00, code};
      ok    = 1'b1;
      if (code <= CODE_LAST_ALPHA) begin
         ch = 8'h41 + code8;
      end else if (code <= CODE_LAST_PUNCT) begin
         ch = 8'h20 + code8 - 8'd26;
      end else if (code <= CODE_LAST_SIGN) begin
         ch = 8'h2C + code8 - 8'd36;
      end else if (code <= CODE_LAST_DIGIT) begin
         ch = 8'h30 + code8 - 8'd40;
      end else if (code <= CODE_LAST_COLON) begin
         ch = 8'h3A + code8 - 8'd50;
      end else if (code == CODE_QUESTION) begin
         ch = 8'h3F;
      end else begin
         ch = 8'h00;
         ok = 1'b0;
      end
      return {ok, ch};
   endfunction

endpackage

// File: rtl/csd_if.sv
// Valid/ready channel interfaces for cover bytes, results and the register write.
// Depends on csd_pkg for field widths.
interface csd_req_if;
   logic                       valid;
   logic                       ready;
   logic [csd_pkg::CHAR_W-1:0] cover_char;
   logic                       last;

   modport source (output valid, output cover_char, output last, input ready);
   modport sink   (input valid, input cover_char, input last, output ready);
endinterface

interface csd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [csd_pkg::CHAR_W-1:0]   out_char;
   logic [csd_pkg::STATUS_W-1:0] status;
   logic [csd_pkg::COUNT_W-1:0]  char_count;

   modport source (output valid, output result_kind, output out_char, output status,
                   output char_count, input ready);
   modport sink   (input valid, input result_kind, input out_char, input status,
                   input char_count, output ready);
endinterface

interface csd_csr_if;
   logic                        valid;
   logic                        ready;
   logic [csd_pkg::COUNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/csd_decoder.sv
// Decoder core: message state, max_chars register and the per-byte decode.
// Depends on csd_pkg for types, constants and the code map.
module csd_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [csd_pkg::CHAR_W-1:0]  cover_char,
   input  logic                        last,
   input  logic                        csr_write,
   input  logic [csd_pkg::COUNT_W-1:0] csr_data,
   output csd_pkg::push_type           push
);

   logic [csd_pkg::COUNT_W-1:0] max_chars_ff,     max_chars_in;
   logic [csd_pkg::CODE_W-1:0]  code_bits_ff,     code_bits_in;
   logic [csd_pkg::BITS_W-1:0]  bit_count_ff,     bit_count_in;
   logic                        eom_seen_ff,      eom_seen_in;
   logic                        invalid_seen_ff,  invalid_seen_in;
   logic [csd_pkg::COUNT_W-1:0] emitted_count_ff, emitted_count_in;

   logic                        is_upper;
   logic                        is_letter;
   logic                        take_bit;
   logic                        complete;
   logic [csd_pkg::CODE_W-1:0]  code;
   logic [csd_pkg::CHAR_W:0]    mapped;
   logic                        emit;
   logic                        eom_now;
   logic                        invalid_now;
   logic [csd_pkg::COUNT_W-1:0] count_now;
   logic [csd_pkg::STATUS_W-1:0] status_now;
   csd_pkg::result_type         char_result;
   csd_pkg::result_type         status_result;

   // Letter classification and code assembly.
   always_comb begin
      is_upper  = (cover_char >= 8'h41) && (cover_char <= 8'h5A);
      is_letter = is_upper || ((cover_char >= 8'h61) && (cover_char <= 8'h7A));
      take_bit  = is_letter && !eom_seen_ff;
      code      = {code_bits_ff[csd_pkg::CODE_W-2:0], is_upper};
      complete  = take_bit && (bit_count_ff == csd_pkg::BITS_LAST);
      mapped    = csd_pkg::map_code(code);
   end

   // Outcome of a completed code, and the values the status sees.
   always_comb begin
      eom_now     = eom_seen_ff || (complete && (code == csd_pkg::CODE_EOM));
      invalid_now = invalid_seen_ff ||
                    (complete && (code != csd_pkg::CODE_EOM) && !mapped[csd_pkg::CHAR_W]);
      emit        = complete && mapped[csd_pkg::CHAR_W] && (emitted_count_ff < max_chars_ff);
      count_now   = emitted_count_ff + {{(csd_pkg::COUNT_W-1){1'b0}}, emit};
      if (max_chars_ff == '0) begin
         status_now = csd_pkg::STATUS_NO_ROOM;
      end else if (!eom_now) begin
         status_now = csd_pkg::STATUS_NO_MARKER;
      end else if (invalid_now) begin
         status_now = csd_pkg::STATUS_INVALID;
      end else begin
         status_now = csd_pkg::STATUS_OK;
      end
   end

   // Results of this byte: the character first, then the status.
   always_comb begin
      char_result.result_kind   = csd_pkg::KIND_CHAR;
      char_result.out_char      = mapped[csd_pkg::CHAR_W-1:0];
      char_result.status        = csd_pkg::STATUS_OK;
      char_result.char_count    = count_now;
      status_result.result_kind = csd_pkg::KIND_STATUS;
      status_result.out_char    = '0;
      status_result.status      = status_now;
      status_result.char_count  = count_now;
      push.first_valid  = accept && (emit || last);
      push.second_valid = accept && emit && last;
      push.first        = emit ? char_result : status_result;
      push.second       = status_result;
   end

   // Next state: advance on accepted letters, clear after the last byte.
   always_comb begin
      max_chars_in     = csr_write ? csr_data : max_chars_ff;
      code_bits_in     = code_bits_ff;
      bit_count_in     = bit_count_ff;
      eom_seen_in      = eom_seen_ff;
      invalid_seen_in  = invalid_seen_ff;
      emitted_count_in = emitted_count_ff;
      if (accept) begin
         if (last) begin
            code_bits_in     = '0;
            bit_count_in     = '0;
            eom_seen_in      = 1'b0;
            invalid_seen_in  = 1'b0;
            emitted_count_in = '0;
         end else if (take_bit) begin
            code_bits_in     = complete ? '0 : code;
            bit_count_in     = complete ? '0 : bit_count_ff + 3'd1;
            eom_seen_in      = eom_now;
            invalid_seen_in  = invalid_now;
            emitted_count_in = count_now;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff     <= csd_pkg::MAX_CHARS_RESET;
         code_bits_ff     <= '0;
         bit_count_ff     <= '0;
         eom_seen_ff      <= 1'b0;
         invalid_seen_ff  <= 1'b0;
         emitted_count_ff <= '0;
      end else begin
         max_chars_ff     <= max_chars_in;
         code_bits_ff     <= code_bits_in;
         bit_count_ff     <= bit_count_in;
         eom_seen_ff      <= eom_seen_in;
         invalid_seen_ff  <= invalid_seen_in;
         emitted_count_ff <= emitted_count_in;
      end
   end

endmodule

// File: rtl/csd_out_queue.sv
// Result queue: takes up to two results per cycle and presents one per cycle while popped.
// Depends on csd_pkg for the result and push types and the queue geometry.
module csd_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  csd_pkg::push_type   push,
   input  logic                pop,
   output logic                space,
   output logic                out_valid,
   output csd_pkg::result_type out_data
);

   csd_pkg::result_type             entry_ff [csd_pkg::QUEUE_DEPTH];
   logic [csd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csd_pkg::QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic [csd_pkg::QUEUE_PTR_W-1:0] wr_next;
   logic [csd_pkg::QUEUE_CNT_W-1:0] push_n;

   // Room for two results keeps a whole byte's output in the queue.
   assign space     = (count_ff <= csd_pkg::QUEUE_CNT_W'(csd_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + csd_pkg::QUEUE_PTR_W'(1);

   // Pointer and count updates.
   always_comb begin
      push_n    = csd_pkg::QUEUE_CNT_W'(push.first_valid) +
                  csd_pkg::QUEUE_CNT_W'(push.second_valid);
      wr_ptr_in = wr_ptr_ff + push_n[csd_pkg::QUEUE_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + csd_pkg::QUEUE_PTR_W'(pop);
      count_in  = count_ff + push_n - csd_pkg::QUEUE_CNT_W'(pop);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// File: rtl/case_stego_six_bit_decoder.sv
// Letter-case decoder, six letters per character. It takes one cover byte per clock cycle
// while req.ready is high and returns one result per cycle while rsp.ready is high: a
// decoded character after each sixth letter that makes a valid code before the marker, up
// to max_chars, and a final status on the byte marked last, so that byte can produce two
// results. Each byte is decoded in the cycle it is accepted and its results go into a
// four-entry result queue; a result is offered on rsp once those ahead of it are taken,
// and a final byte's status follows the character it completes. req.ready is high while
// the queue holds two results or fewer, so with rsp.ready held high the block never
// stalls the input. Reset leaves max_chars at 65535. Write max_chars only when no results
// are pending. Characters already delivered are void if the final status is not ok.
module case_stego_six_bit_decoder (
   input logic           clock,
   input logic           reset,
   csd_req_if.sink       req,
   csd_rsp_if.source     rsp,
   csd_csr_if.sink       csr
);

   logic                req_accept;
   logic                rsp_accept;
   logic                queue_space;
   csd_pkg::push_type   push;
   csd_pkg::result_type head;

   // Channel handshakes.
   assign req.ready  = queue_space;
   assign csr.ready  = 1'b1;
   assign req_accept = req.valid && req.ready;
   assign rsp_accept = rsp.valid && rsp.ready;

   // Per-byte decode and message state.
   csd_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .cover_char (req.cover_char),
      .last       (req.last),
      .csr_write  (csr.valid),
      .csr_data   (csr.data),
      .push       (push)
   );

   // Results wait here until the sink takes them.
   csd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .space     (queue_space),
      .out_valid (rsp.valid),
      .out_data  (head)
   );

   assign rsp.result_kind = head.result_kind;
   assign rsp.out_char    = head.out_char;
   assign rsp.status      = head.status;
   assign rsp.char_count  = head.char_count;

   // Two results come only from a final byte that also completes a character.
   assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> (push.first_valid && req.last &&
                             push.first.result_kind == csd_pkg::KIND_CHAR))
      else $error("second result without a character on the final byte");

   // Results are produced only by an accepted byte.
   assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> req_accept)
      else $error("result pushed without an accepted transaction");

   // The queue is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result valid after reset");

   // A status result carries no character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.result_kind == csd_pkg::KIND_STATUS) |-> (rsp.out_char == '0))
      else $error("status result with a nonzero character");

endmodule

// File: tb/sv/csd_checker.sv
`timescale 1ns / 1ps
// Passive checker for the letter-case decoder: watches the byte, result and register channels.
// Predicts the results of each accepted cover byte and compares them with the block's output.
// Depends on csd_pkg and the channel interfaces of csd_if.sv.
module csd_checker
   import csd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   csd_req_if   req,
   csd_rsp_if   rsp,
   csd_csr_if   csr,
   output int   fail_count,
   output int   pending
);

   // Predicted decoder state for the message in progress.
   logic [CODE_W-1:0]  shift_code;
   logic [BITS_W-1:0]  letters_held;
   logic               marker_seen;
   logic               bad_code_seen;
   logic [COUNT_W-1:0] chars_out;
   logic [COUNT_W-1:0] room;

   // Results the block still owes, oldest first.
   result_type owed_results[$];

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void clear_message();
      shift_code    = '0;
      letters_held  = '0;
      marker_seen   = 1'b0;
      bad_code_seen = 1'b0;
      chars_out     = '0;
   endfunction

   // Character for a valid code: letters, then space to ')', ',' to '/', digits, ':' ';' '?'.
   function automatic logic [CHAR_W-1:0] char_of_code(input logic [CODE_W-1:0] code);
      int unsigned k;
      k = code;
      if (code <= CODE_LAST_ALPHA) return 8'("A" + k);
      if (code <= CODE_LAST_PUNCT) return 8'(" " + k - (CODE_LAST_ALPHA + 1));
      if (code <= CODE_LAST_SIGN)  return 8'("," + k - (CODE_LAST_PUNCT + 1));
      if (code <= CODE_LAST_DIGIT) return 8'("0" + k - (CODE_LAST_SIGN + 1));
      if (code <= CODE_LAST_COLON) return 8'(":" + k - (CODE_LAST_DIGIT + 1));
      return "?";
   endfunction

   // Works out the results of one accepted cover byte and queues them.
   task automatic decode_byte(input logic [CHAR_W-1:0] c, input logic is_last);
      logic              is_upper;
      logic              is_lower;
      logic [CODE_W-1:0] code;
      result_type        r;
      is_upper = (c >= "A") && (c <= "Z");
      is_lower = (c >= "a") && (c <= "z");
      // Letters add one case bit each until the end marker has been seen.
      if (!marker_seen && (is_upper || is_lower)) begin
         shift_code   = {shift_code[CODE_W-2:0], is_upper};
         letters_held = letters_held + 1'b1;
         if (letters_held == BITS_LAST + 1'b1) begin
            code         = shift_code;
            shift_code   = '0;
            letters_held = '0;
            if (code == CODE_EOM) begin
               marker_seen = 1'b1;
            end else if (code > CODE_QUESTION) begin
               bad_code_seen = 1'b1;
            end else if (chars_out < room) begin
               chars_out     = chars_out + 1'b1;
               r.result_kind = KIND_CHAR;
               r.out_char    = char_of_code(code);
               r.status      = STATUS_OK;
               r.char_count  = chars_out;
               owed_results.push_back(r);
            end
         end
      end
      // The final byte closes the message with a status.
      if (is_last) begin
         r.result_kind = KIND_STATUS;
         r.out_char    = '0;
         r.char_count  = chars_out;
         if (room == '0) begin
            r.status = STATUS_NO_ROOM;
         end else if (!marker_seen) begin
            r.status = STATUS_NO_MARKER;
         end else if (bad_code_seen) begin
            r.status = STATUS_INVALID;
         end else begin
            r.status = STATUS_OK;
         end
         owed_results.push_back(r);
         clear_message();
      end
   endtask

   // Compares one delivered result with the oldest owed one, field by field.
   task automatic check_result();
      result_type want;
      if (owed_results.size() == 0) begin
         report_error($sformatf("result with none owed: kind %0d char %h status %0d count %0d",
                                rsp.result_kind, rsp.out_char, rsp.status, rsp.char_count));
      end else begin
         want = owed_results.pop_front();
         if (rsp.result_kind !== want.result_kind)
            report_error($sformatf("result_kind: got %0d, expected %0d",
                                   rsp.result_kind, want.result_kind));
         if (rsp.out_char !== want.out_char)
            report_error($sformatf("out_char: got %h, expected %h", rsp.out_char, want.out_char));
         if (rsp.status !== want.status)
            report_error($sformatf("status: got %0d, expected %0d", rsp.status, want.status));
         if (rsp.char_count !== want.char_count)
            report_error($sformatf("char_count: got %0d, expected %0d",
                                   rsp.char_count, want.char_count));
      end
   endtask

   // Every transaction is taken at the rising edge at which it completes.
   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         room = MAX_CHARS_RESET;
         owed_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_result();
         if (csr.valid && csr.ready) room = csr.data;
         if (req.valid && req.ready) decode_byte(req.cover_char, req.last);
      end
      pending <= owed_results.size();
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the letter-case decoder testbench: clock, reset, cover-text stimulus and verdict.
// Depends on csd_pkg, the channel interfaces, the decoder and the csd_checker module.
module tb;
   import csd_pkg::*;

   localparam int RANDOM_ITEMS = 1450;
   localparam int PHASES       = 8;
   localparam int HALF_PERIOD  = 10;

   // Ways a broken message can end.
   typedef enum int {TAIL_NONE, TAIL_MARKER, TAIL_PARTIAL, TAIL_FILLER} tail_kind_e;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   noise_pct      = 0;
   int   useful_items   = 0;

   // Cover bytes of the message being built.
   logic [CHAR_W-1:0] cover_q[$];

   csd_req_if req_ch ();
   csd_rsp_if rsp_ch ();
   csd_csr_if csr_ch ();

   case_stego_six_bit_decoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   csd_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   // Generous limit: the slowest correct run takes well under a tenth of this.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: ready drops at random with the current stall rate.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic is_letter(input logic [CHAR_W-1:0] b);
      return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
   endfunction

   function automatic logic [CHAR_W-1:0] case_letter(input logic upper);
      int unsigned k;
      k = $urandom_range(0, 25);
      return upper ? 8'("A" + k) : 8'("a" + k);
   endfunction

   // Any byte that is not a letter, high half included.
   function automatic logic [CHAR_W-1:0] filler_byte();
      logic [CHAR_W-1:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_letter(b));
      return b;
   endfunction

   // Six letters carrying one code, most significant bit first, with optional filler.
   task automatic add_code(input logic [CODE_W-1:0] code);
      for (int i = CODE_W - 1; i >= 0; i--) begin
         if ($urandom_range(0, 99) < noise_pct) cover_q.push_back(filler_byte());
         cover_q.push_back(case_letter(code[i]));
      end
   endtask

   // One transaction on the byte channel, after a random idle gap.
   task automatic send_byte(input logic [CHAR_W-1:0] c, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cover_char <= c;
      req_ch.last       <= is_last;
      do @(posedge clock); while (!req_ch.ready);
      useful_items++;
   endtask

   // Stops sending and waits until every owed result has been delivered.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_max_chars(input logic [COUNT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Sends the built message, last flag on its final byte. At split_at the block is
   // drained and max_chars rewritten in the middle of the message.
   task automatic send_message(input int split_at);
      for (int i = 0; i < cover_q.size(); i++) begin
         if (i == split_at) begin
            drain();
            set_max_chars(16'($urandom_range(0, 8)));
         end
         send_byte(cover_q[i], i == cover_q.size() - 1);
      end
      cover_q.delete();
   endtask

   // Mostly well-formed messages; the rest may carry invalid codes or end early.
   task automatic random_message();
      int                shape;
      int                n_chars;
      tail_kind_e        tail;
      logic [CODE_W-1:0] code;
      shape     = $urandom_range(0, 99);
      n_chars   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      noise_pct = 10 * $urandom_range(0, 3);
      if (shape < 70) begin
         repeat (n_chars) add_code(6'($urandom_range(0, CODE_QUESTION)));
         add_code(CODE_EOM);
         // Anything after the marker, letters too, is ignored.
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 8)) cover_q.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat (n_chars) begin
            if ($urandom_range(0, 3) == 0) begin
               code = 6'($urandom_range(CODE_QUESTION + 1, CODE_EOM - 1));
            end else begin
               code = 6'($urandom_range(0, CODE_QUESTION));
            end
            add_code(code);
         end
         tail = tail_kind_e'($urandom_range(TAIL_NONE, TAIL_FILLER));
         case (tail)
            TAIL_MARKER: add_code(CODE_EOM);
            TAIL_PARTIAL: begin
               repeat ($urandom_range(1, 5)) begin
                  cover_q.push_back(case_letter(1'($urandom_range(0, 1))));
               end
            end
            TAIL_FILLER: repeat ($urandom_range(1, 6)) cover_q.push_back(filler_byte());
            default: ;
         endcase
      end
      if (cover_q.size() == 0) cover_q.push_back(filler_byte());
   endtask

   // Main stimulus.
   initial begin
      logic [COUNT_W-1:0] room_value;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.cover_char <= '0;
      req_ch.last       <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, the last valid code and the marker ending on the last byte.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      add_code(CODE_QUESTION);
      add_code(CODE_EOM);
      send_message(-1);
      // A lone trailing letter as the last byte: no marker.
      send_byte("z", 1'b1);
      // An invalid code followed by the marker.
      add_code(CODE_EOM - 1);
      add_code(CODE_EOM);
      send_message(-1);

      // Random messages over several register settings and idling patterns.
      useful_items = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         case (ph)
            0: room_value = MAX_CHARS_RESET;
            1: room_value = '0;
            2: room_value = 16'd1;
            3: room_value = 16'($urandom_range(2, 6));
            4: room_value = 16'($urandom_range(0, 65535));
            5: room_value = '0;
            6: room_value = 16'd2;
            default: room_value = MAX_CHARS_RESET;
         endcase
         set_max_chars(room_value);
         while (useful_items < RANDOM_ITEMS * (ph + 1) / PHASES) begin
            random_message();
            if (($urandom_range(0, 11) == 0) && (cover_q.size() > 12)) begin
               send_message($urandom_range(6, cover_q.size() - 1));
            end else begin
               send_message(-1);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
